### src/dedup_history_table_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the duplicate history table
// Shared shorthand for the concurrent checks of the history table unit.
// ---------------------------------------------------------------------------
`ifndef DEDUP_HISTORY_TABLE_UNIT_ASSERT_SVH
`define DEDUP_HISTORY_TABLE_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define DHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/dht_pkg.sv
// ---------------------------------------------------------------------------
// Duplicate history table package
// Request and status codes, controller states and the stored entry layout.
// ---------------------------------------------------------------------------
package dht_pkg;

  localparam int LIFE_W = 40;
  localparam int THR_W  = 7;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET  = 40'd30000000000;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 7'd10;

  // Register indexes, decoded from the 8-byte register slot.
  localparam logic REG_LIFETIME  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_FRESHEN = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FRESH,
    S_LOOK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [31:0] serial;
    logic [63:0] tag;
    logic        present;
    logic [63:0] expiry;
  } entry_t;

endpackage

### src/dedup_history_table_unit.sv
// ---------------------------------------------------------------------------
// Duplicate history table unit
// Aging FIFO history of publications with append, freshen, lookup and clear.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   request   in         in_valid_i / in_ready_o    req_type, time, id, serial, sender
//   result    out        out_valid_o / out_ready_i  status, found, tag, count
//   config    in         APB psel/penable/pready    lifetime (0x0), threshold (0x8)
//
// One request at a time, taken only while idle. Append, clear, a held-back freshen
// and a lookup on an empty table go straight from execution to the result state.
// A freshen pass removes expired entries from the oldest end, stopping at the first
// unexpired one or an empty table; a lookup scans from the oldest entry to a hit or the last.
// Reset clears the control state only; the entry memory is read only within the held
// window. A stalled result waits in the output register while the next request runs.
//
module dedup_history_table_unit import dht_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] time_now_i,
  input  logic [63:0] id_high_i,
  input  logic [63:0] id_low_i,
  input  logic [31:0] serial_i,
  input  logic [63:0] sender_tag_i,
  input  logic        sender_present_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [63:0] found_tag_o,
  output logic        found_present_o,
  output logic [$clog2(DEPTH+1)-1:0] entry_count_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  // Position of the entry that lies off entries past base, wrapped to the
  // table. The sum always stays below twice the depth, so one subtract does.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers. The register slot is chosen by address bit 3;
  // the byte offset within a slot is ignored.
  // ---------------------------------------------------------------------
  logic [LIFE_W-1:0] lifetime_q;
  logic [THR_W-1:0]  thr_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= LIFETIME_RESET;
      thr_q      <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      if (paddr[3] == REG_LIFETIME) begin
        lifetime_q <= pwdata[LIFE_W-1:0];
      end else begin
        thr_q <= pwdata[THR_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == REG_THRESHOLD) begin
      prdata = {{(64-THR_W){1'b0}}, thr_q};
    end else begin
      prdata = {{(64-LIFE_W){1'b0}}, lifetime_q};
    end
  end

  // ---------------------------------------------------------------------
  // Entry memory: one write port, one registered read port.
  // ---------------------------------------------------------------------
  entry_t             mem [DEPTH];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  entry_t             rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Captured request. Payload registers, loaded when a beat is accepted.
  // ---------------------------------------------------------------------
  req_e        req_q;
  logic [63:0] now_q;
  logic [63:0] idh_q;
  logic [63:0] idl_q;
  logic [31:0] serial_q;
  logic [63:0] tag_q;
  logic        pres_q;
  logic        in_fire;

  assign in_fire = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q    <= req_e'(req_type_i);
      now_q    <= time_now_i;
      idh_q    <= id_high_i;
      idl_q    <= id_low_i;
      serial_q <= serial_i;
      tag_q    <= sender_tag_i;
      pres_q   <= sender_present_i;
    end
  end

  // ---------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   oldest_q, oldest_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_last_q, rd_last_d;

  status_e            res_status_q, res_status_d;
  logic               res_found_q, res_found_d;
  logic [63:0]        res_tag_q, res_tag_d;
  logic               res_pres_q, res_pres_d;
  logic               load_out;

  logic [64:0]        exp_sum;
  logic [63:0]        expiry;
  logic               hit;
  logic [IDX_W-1:0]   oldest_next;

  // Expiry saturates at the top of the 64-bit time range.
  assign exp_sum     = {1'b0, now_q} + {25'd0, lifetime_q};
  assign expiry      = exp_sum[64] ? {64{1'b1}} : exp_sum[63:0];
  assign hit         = (rdata_q.serial == serial_q) && (rdata_q.id_high == idh_q) &&
                       (rdata_q.id_low == idl_q);
  assign oldest_next = slot_at(oldest_q, CNT_W'(1));

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      oldest_q  <= '0;
      count_q   <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_tag_q    <= res_tag_d;
    res_pres_q   <= res_pres_d;
  end

  always_comb begin
    state_d      = state_q;
    oldest_d     = oldest_q;
    count_d      = count_q;
    issue_d      = issue_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = 1'b0;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_tag_d    = res_tag_q;
    res_pres_d   = res_pres_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_at(oldest_q, count_q);
    mem_wdata    = '{id_high: idh_q, id_low: idl_q, serial: serial_q,
                     tag: pres_q ? tag_q : 64'd0, present: pres_q, expiry: expiry};
    mem_re       = 1'b0;
    mem_raddr    = oldest_q;
    load_out     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = STAT_OK;
        res_found_d  = 1'b0;
        res_tag_d    = 64'd0;
        res_pres_d   = 1'b0;
        state_d      = S_DONE;
        case (req_q)
          REQ_APPEND: begin
            if (count_q == CNT_W'(DEPTH)) begin
              res_status_d = STAT_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
          REQ_FRESHEN: begin
            // The threshold is tested once; a nonzero count follows from it.
            if (CMP_W'(count_q) > CMP_W'(thr_q)) begin
              mem_re    = 1'b1;
              mem_raddr = oldest_q;
              state_d   = S_FRESH;
            end
          end
          REQ_LOOKUP: begin
            res_status_d = STAT_MISS;
            if (count_q != '0) begin
              issue_d = '0;
              state_d = S_LOOK;
            end
          end
          REQ_CLEAR: begin
            count_d  = '0;
            oldest_d = '0;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_FRESH: begin
        // The read data holds the oldest entry. The entry behind it is read
        // in the same cycle so that one entry can be dropped every cycle.
        if (now_q >= rdata_q.expiry) begin
          oldest_d = oldest_next;
          count_d  = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = oldest_next;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_LOOK: begin
        if (rd_vld_q && hit) begin
          res_status_d = STAT_OK;
          res_found_d  = 1'b1;
          res_pres_d   = rdata_q.present;
          res_tag_d    = rdata_q.present ? rdata_q.tag : 64'd0;
          state_d      = S_DONE;
        end else if (rd_vld_q && rd_last_q) begin
          state_d = S_DONE;
        end else if (issue_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = slot_at(oldest_q, issue_q);
          issue_d   = issue_q + CNT_W'(1);
          rd_vld_d  = 1'b1;
          rd_last_d = (issue_q == (count_q - CNT_W'(1)));
        end
      end

      S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic out_valid_q;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o        <= res_status_q;
      found_o         <= res_found_q;
      found_tag_o     <= res_tag_q;
      found_present_o <= res_pres_q;
      entry_count_o   <= count_q;
    end
  end

endmodule

### src/dht_checker.sv
// ---------------------------------------------------------------------------
// Duplicate history table checker
// Port-level checks on the result channel of the history table unit.
// ---------------------------------------------------------------------------
`include "dedup_history_table_unit_assert.svh"

module dht_checker import dht_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        found_o,
  input logic [63:0] found_tag_o,
  input logic        found_present_o,
  input logic [$clog2(DEPTH+1)-1:0] entry_count_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  `DHT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result beat dropped while stalled")
  `DHT_ASSERT(a_found_ok, clk_i, rst_ni, out_valid_o && found_o |-> status_o == STAT_OK, "hit reported with error status")
  `DHT_ASSERT(a_miss_clean, clk_i, rst_ni, out_valid_o && !found_o |-> found_tag_o == 64'd0 && !found_present_o, "sender fields set without a hit")
  `DHT_ASSERT(a_full_count, clk_i, rst_ni, out_valid_o && status_o == STAT_FULL |-> entry_count_o == CNT_W'(DEPTH), "full status with room left")
  `DHT_ASSERT(a_count_range, clk_i, rst_ni, out_valid_o |-> entry_count_o <= CNT_W'(DEPTH), "entry count beyond depth")

endmodule

bind dedup_history_table_unit dht_checker #(.DEPTH(DEPTH)) u_dht_checker (.*);
